/* rtl/adsr_envelope_gain_macros.svh */
// Assertion macros shared by the envelope gain RTL.
`ifndef ADSR_ENVELOPE_GAIN_MACROS_SVH
`define ADSR_ENVELOPE_GAIN_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ADSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ADSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/adsr_pkg.sv */
// Shared constants and types for the ADSR envelope gain block.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

  // Default widths of the audio sample and of the time registers.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF   = 20;

  // Gain levels are unsigned Q1.15.
  localparam int GAIN_WIDTH = 16;
  localparam int FRAC_BITS  = 15;

  // The divider produces one quotient bit per step.
  localparam int QUO_STEPS      = GAIN_WIDTH;
  localparam int STEP_CNT_WIDTH = $clog2(QUO_STEPS);

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ATTACK_SAMPLES  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ATTACK_LEVEL    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DECAY_SAMPLES   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SUSTAIN_LEVEL   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_SAMPLES = 3'd4;

  // Configuration reset values.
  localparam int RST_ATTACK_SAMPLES  = 480;
  localparam int RST_ATTACK_LEVEL    = 32768;
  localparam int RST_DECAY_SAMPLES   = 4800;
  localparam int RST_SUSTAIN_LEVEL   = 32768;
  localparam int RST_RELEASE_SAMPLES = 9600;

  // Operation codes of an input item.
  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_NOTE_OFF = 2'd2;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/adsr_envelope_gain.sv */
// Top level of the ADSR envelope gain block: sequencer, shared multiplier and divider, and state.
// A sample item passes the states PHASE, MUL, DIVST, DIVW, SCALE and SAT when a division is
// needed (attack, decay or release); in sustain or silence DIVW is skipped.
// The 16-step shared divider sets the wait in DIVW; the next item transfers only once
// the sequencer is back in idle. Note items give no result. Output waits in a register.
// Synchronous active-low reset sets the configuration defaults and gate closed.
`timescale 1ns / 1ps
`default_nettype none
`include "adsr_envelope_gain_macros.svh"

module adsr_envelope_gain #(
  parameter int SAMPLE_WIDTH = adsr_pkg::SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH   = adsr_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [1:0]                             in_operation,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         in_sample_in,
  // Result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]              out_sample_out,
  output logic [adsr_pkg::GAIN_WIDTH-1:0]             out_gain,
  output logic                                        out_gate_open,
  // Configuration write channel
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [adsr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [((TIME_WIDTH > adsr_pkg::GAIN_WIDTH) ?
                      TIME_WIDTH : adsr_pkg::GAIN_WIDTH)-1:0] cfg_data
);
  import adsr_pkg::*;

  localparam int CFG_WIDTH = (TIME_WIDTH > GAIN_WIDTH) ? TIME_WIDTH : GAIN_WIDTH;
  localparam int EW = TIME_WIDTH + 1;
  localparam int NW = EW + GAIN_WIDTH;
  localparam int MA = ((EW > SAMPLE_WIDTH) ? EW : SAMPLE_WIDTH) + 1;
  localparam int MB = GAIN_WIDTH + 1;
  localparam int PW = MA + MB;
  localparam int QW = SAMPLE_WIDTH + 2;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PHASE = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIVST = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_SAT   = 3'd6;

  logic [TIME_WIDTH-1:0] attack_samples;
  logic [GAIN_WIDTH-1:0] attack_level;
  logic [TIME_WIDTH-1:0] decay_samples;
  logic [GAIN_WIDTH-1:0] sustain_level;
  logic [TIME_WIDTH-1:0] release_samples;

  logic [2:0]                     state_r;
  logic                           gate_r;
  logic [EW-1:0]                  elapsed_r;
  logic [TIME_WIDTH-1:0]          release_r;
  logic [GAIN_WIDTH-1:0]          held_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic                           lt_attack_r;
  logic [EW-1:0]                  diff_r;
  logic [TIME_WIDTH-1:0]          rclamp_r;
  logic                           skip_r;
  logic                           neg_r;
  logic [GAIN_WIDTH-1:0]          base_r;
  logic [TIME_WIDTH-1:0]          den_r;
  logic signed [PW-1:0]           prod_r;
  logic [GAIN_WIDTH-1:0]          gain_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic [GAIN_WIDTH-1:0]          out_gain_r;
  logic                           out_gate_r;

  logic                           in_xfer;
  logic                           out_free;
  logic                           decay_on;
  logic [TIME_WIDTH-1:0]          decay_left;
  logic                           a_ge_s;
  logic [GAIN_WIDTH-1:0]          level_span;
  logic                           rel_on;
  logic [EW-1:0]                  mul_a_u;
  logic [GAIN_WIDTH-1:0]          mul_b_u;
  logic [TIME_WIDTH-1:0]          den_nxt;
  logic [GAIN_WIDTH-1:0]          base_nxt;
  logic                           neg_nxt;
  logic                           skip_nxt;
  logic signed [MA-1:0]           mul_a;
  logic signed [MB-1:0]           mul_b;
  logic signed [PW-1:0]           prod;
  logic                           div_start;
  logic [GAIN_WIDTH-1:0]          div_quo;
  div_stat_t                      div_stat;
  logic [QW-1:0]                  scaled;
  logic                           sat_ok;
  logic signed [SAMPLE_WIDTH-1:0] sat_val;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  adsr_cfg #(
    .TIME_WIDTH (TIME_WIDTH),
    .CFG_WIDTH  (CFG_WIDTH)
  ) u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr_en           (cfg_valid && cfg_ready),
    .wr_index        (cfg_index),
    .wr_data         (cfg_data),
    .attack_samples  (attack_samples),
    .attack_level    (attack_level),
    .decay_samples   (decay_samples),
    .sustain_level   (sustain_level),
    .release_samples (release_samples)
  );

  // Handshake status.
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Phase decode from the registered comparisons of the previous state.
  assign decay_on   = diff_r < EW'(decay_samples);
  assign decay_left = decay_samples - diff_r[TIME_WIDTH-1:0];
  assign a_ge_s     = attack_level >= sustain_level;
  assign level_span = a_ge_s ? (attack_level - sustain_level)
                             : (sustain_level - attack_level);
  assign rel_on     = (release_r != '0) && (release_samples != '0);

  always_comb begin
    mul_a_u  = '0;
    mul_b_u  = '0;
    den_nxt  = release_samples;
    base_nxt = '0;
    neg_nxt  = 1'b0;
    skip_nxt = 1'b1;
    priority if (gate_r && lt_attack_r) begin
      mul_a_u  = elapsed_r;
      mul_b_u  = attack_level;
      den_nxt  = attack_samples;
      skip_nxt = 1'b0;
    end else if (gate_r && decay_on) begin
      mul_a_u  = EW'(decay_left);
      mul_b_u  = level_span;
      den_nxt  = decay_samples;
      base_nxt = sustain_level;
      neg_nxt  = !a_ge_s;
      skip_nxt = 1'b0;
    end else if (gate_r) begin
      base_nxt = sustain_level;
    end else if (rel_on) begin
      mul_a_u  = EW'(rclamp_r);
      mul_b_u  = held_r;
      skip_nxt = 1'b0;
    end else begin
      base_nxt = '0;
    end
  end

  // Shared multiplier: phase product, then sample times gain.
  assign mul_a = (state_r == S_SCALE) ? MA'(x_r) : $signed(MA'(mul_a_u));
  assign mul_b = (state_r == S_SCALE) ? $signed({1'b0, gain_r}) : $signed({1'b0, mul_b_u});
  assign prod  = PW'(mul_a * mul_b);

  // Shared divider for the ramp quotients.
  assign div_start = (state_r == S_DIVST) && !skip_r;

  adsr_div #(
    .NUM_WIDTH (NW),
    .DEN_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r[NW-1:0]),
    .den   (den_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Floor shift by the fraction bits, then saturation to the sample range.
  assign scaled  = prod_r[SAMPLE_WIDTH+FRAC_BITS+1:FRAC_BITS];
  assign sat_ok  = (scaled[QW-1:SAMPLE_WIDTH-1] == '0) ||
                   (scaled[QW-1:SAMPLE_WIDTH-1] == '1);
  assign sat_val = sat_ok ? $signed(scaled[SAMPLE_WIDTH-1:0]) :
                   scaled[QW-1] ? $signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}) :
                                  $signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});

  // Sequencer, envelope state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gate_r      <= 1'b0;
      elapsed_r   <= '0;
      release_r   <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_operation)
              OP_NOTE_ON: begin
                elapsed_r <= '0;
                gate_r    <= 1'b1;
              end
              OP_NOTE_OFF: begin
                gate_r    <= 1'b0;
                release_r <= release_samples;
              end
              OP_SAMPLE: begin
                x_r     <= in_sample_in;
                state_r <= S_PHASE;
              end
              default: begin
              end
            endcase
          end
        end
        S_PHASE: begin
          lt_attack_r <= elapsed_r < EW'(attack_samples);
          diff_r      <= elapsed_r - EW'(attack_samples);
          rclamp_r    <= (release_r > release_samples) ? release_samples : release_r;
          state_r     <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= prod;
          den_r   <= den_nxt;
          base_r  <= base_nxt;
          neg_r   <= neg_nxt;
          skip_r  <= skip_nxt;
          state_r <= S_DIVST;
        end
        S_DIVST: begin
          if (skip_r) begin
            gain_r  <= base_r;
            state_r <= S_SCALE;
          end else begin
            state_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_stat.done) begin
            gain_r  <= neg_r ? (base_r - div_quo) : (base_r + div_quo);
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod_r  <= prod;
          state_r <= S_SAT;
        end
        S_SAT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= sat_val;
            out_gain_r   <= gain_r;
            out_gate_r   <= gate_r;
            if (gate_r) begin
              held_r <= gain_r;
              if (elapsed_r != '1) begin
                elapsed_r <= elapsed_r + 1'b1;
              end
            end else if (release_r != '0) begin
              release_r <= release_r - 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_gain       = out_gain_r;
  assign out_gate_open  = out_gate_r;

  // Checks on the envelope and the sequencing.
  `ADSR_ASSERT_NOW(a_release_bound, out_valid_r && !out_gate_r, out_gain_r <= held_r,
                   "release gain above held gain")
  `ADSR_ASSERT_NOW(a_zero_gain_silent, out_valid_r && (out_gain_r == '0),
                   out_sample_r == '0, "zero gain with non-zero sample")
  `ADSR_ASSERT_NOW(a_div_done_waited, div_stat.done, state_r == S_DIVW,
                   "quotient ready outside the wait state")

endmodule

`default_nettype wire

/* rtl/adsr_cfg.sv */
// Configuration register file of the ADSR envelope gain block.
`timescale 1ns / 1ps
`default_nettype none

module adsr_cfg #(
  parameter int TIME_WIDTH = adsr_pkg::TIME_WIDTH_DEF,
  parameter int CFG_WIDTH  = adsr_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                wr_en,
  input  wire logic [adsr_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  wire logic [CFG_WIDTH-1:0]                wr_data,
  output logic [TIME_WIDTH-1:0]                    attack_samples,
  output logic [adsr_pkg::GAIN_WIDTH-1:0]          attack_level,
  output logic [TIME_WIDTH-1:0]                    decay_samples,
  output logic [adsr_pkg::GAIN_WIDTH-1:0]          sustain_level,
  output logic [TIME_WIDTH-1:0]                    release_samples
);
  import adsr_pkg::*;

  logic [TIME_WIDTH-1:0] attack_samples_r;
  logic [GAIN_WIDTH-1:0] attack_level_r;
  logic [TIME_WIDTH-1:0] decay_samples_r;
  logic [GAIN_WIDTH-1:0] sustain_level_r;
  logic [TIME_WIDTH-1:0] release_samples_r;

  // Write decode; an index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_samples_r  <= TIME_WIDTH'(RST_ATTACK_SAMPLES);
      attack_level_r    <= GAIN_WIDTH'(RST_ATTACK_LEVEL);
      decay_samples_r   <= TIME_WIDTH'(RST_DECAY_SAMPLES);
      sustain_level_r   <= GAIN_WIDTH'(RST_SUSTAIN_LEVEL);
      release_samples_r <= TIME_WIDTH'(RST_RELEASE_SAMPLES);
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_ATTACK_SAMPLES:  attack_samples_r  <= wr_data[TIME_WIDTH-1:0];
        CFG_ATTACK_LEVEL:    attack_level_r    <= wr_data[GAIN_WIDTH-1:0];
        CFG_DECAY_SAMPLES:   decay_samples_r   <= wr_data[TIME_WIDTH-1:0];
        CFG_SUSTAIN_LEVEL:   sustain_level_r   <= wr_data[GAIN_WIDTH-1:0];
        CFG_RELEASE_SAMPLES: release_samples_r <= wr_data[TIME_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign attack_samples  = attack_samples_r;
  assign attack_level    = attack_level_r;
  assign decay_samples   = decay_samples_r;
  assign sustain_level   = sustain_level_r;
  assign release_samples = release_samples_r;

endmodule

`default_nettype wire

/* rtl/adsr_div.sv */
// Iterative restoring divider giving a 16-bit quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "adsr_envelope_gain_macros.svh"

module adsr_div #(
  parameter int NUM_WIDTH = adsr_pkg::TIME_WIDTH_DEF + adsr_pkg::GAIN_WIDTH + 1,
  parameter int DEN_WIDTH = adsr_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [NUM_WIDTH-1:0]       num,
  input  wire logic [DEN_WIDTH-1:0]       den,
  output logic [adsr_pkg::GAIN_WIDTH-1:0] quo,
  output adsr_pkg::div_stat_t             stat
);
  import adsr_pkg::*;

  logic [NUM_WIDTH-1:0]      rem_r;
  logic [NUM_WIDTH-1:0]      dsh_r;
  logic [GAIN_WIDTH-1:0]     quo_r;
  logic [STEP_CNT_WIDTH-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [NUM_WIDTH:0]        trial;
  logic                      fits;

  // The one subtractor: trial remainder against the shifted divisor.
  assign trial = {1'b0, rem_r} - {1'b0, dsh_r};
  assign fits  = !trial[NUM_WIDTH];

  // Control: a start loads the operands, then sixteen steps follow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_WIDTH'(QUO_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient is known to fit in sixteen bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= NUM_WIDTH'({den, {(QUO_STEPS-1){1'b0}}});
      quo_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= trial[NUM_WIDTH-1:0];
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[GAIN_WIDTH-2:0], fits};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // Checks on the step sequencing.
  `ADSR_ASSERT_NEXT(a_start_busy, start, busy_r, "divider not busy after start")
  `ADSR_ASSERT_NOW(a_done_not_busy, done_r, !busy_r, "divider done while still busy")
  `ADSR_ASSERT_NOW(a_done_after_step, done_r, $past(busy_r), "divider done without a step")

endmodule

`default_nettype wire
